// ===== rtl/jfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jfsp_pkg
// Types and constants shared by the joystick frame to servo pulse block.
// ----------------------------------------------------------------------------
package jfsp_pkg;

  // default depth of the queue between front and back
  localparam int JFSP_QUEUE_DEPTH = 2;

  // result kinds
  localparam logic [1:0] KIND_SILENCE  = 2'd0;
  localparam logic [1:0] KIND_STEER    = 2'd1;
  localparam logic [1:0] KIND_THROTTLE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_STEER_ID    = 2'd0;
  localparam logic [1:0] REG_THROTTLE_ID = 2'd1;
  localparam logic [1:0] REG_TRIM_LIMIT  = 2'd2;

  // configuration reset values
  localparam logic [10:0] STEER_ID_RESET    = 11'd2;
  localparam logic [10:0] THROTTLE_ID_RESET = 11'd4;
  localparam logic [8:0]  TRIM_LIMIT_RESET  = 9'd500;

  // trim code field of the second payload byte
  localparam logic [7:0] TRIM_CODE_MASK = 8'hFC;
  localparam logic [7:0] TRIM_CODE_DOWN = 8'h04;
  localparam logic [7:0] TRIM_CODE_UP   = 8'h08;

  // pulse arithmetic in sixteenths of a microsecond
  localparam logic [15:0] BASE_LOW16  = 16'd24000;  // 1500 us
  localparam logic [15:0] BASE_HIGH16 = 16'd32000;  // 2000 us
  localparam logic [15:0] MIRROR16    = 16'd48000;  // 2 * 1500 us
  localparam logic [15:0] HALF16      = 16'd8;

  typedef enum logic [1:0] {
    TRIM_HOLD,
    TRIM_DOWN,
    TRIM_UP
  } trim_op_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [11:0] pulse_width;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [10:0] value;
  } cfg_item_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    trim_op_t    trim_op;
    logic [11:0] raw_pulse;
  } entry_t;

  // configuration seen by the front and back
  typedef struct packed {
    logic [10:0] steer_id;
    logic [10:0] thr_id;
    logic [8:0]  trim_limit;
  } cfg_regs_t;

endpackage

// ===== rtl/jfsp_chan_if.sv =====
// ----------------------------------------------------------------------------
// jfsp_chan_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface jfsp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/jfsp_fifo.sv =====
// ----------------------------------------------------------------------------
// jfsp_fifo
// Small register queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module jfsp_fifo #(
  parameter int DEPTH = jfsp_pkg::JFSP_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jfsp_pkg::entry_t push_data,
  input  logic             pop,
  output jfsp_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import jfsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== rtl/jfsp_front.sv =====
// ----------------------------------------------------------------------------
// jfsp_front
// Accepts frames, matches the identifier and forms the untrimmed pulse.
// ----------------------------------------------------------------------------
module jfsp_front (
  jfsp_chan_if.sink            frames,
  input  jfsp_pkg::cfg_regs_t  cfg_regs,
  input  logic                 q_full,
  output logic                 q_push,
  output jfsp_pkg::entry_t     q_data
);
  import jfsp_pkg::*;

  logic [9:0]  stick;
  logic [8:0]  off;
  logic [12:0] off15;
  logic [15:0] n_base;
  logic [15:0] n_dir;
  logic [15:0] n_round;
  logic [7:0]  code;
  logic        is_steer;
  logic        is_throttle;

  assign frames.ready = !q_full;
  assign q_push       = frames.valid && !q_full;

  // identifier match, steering wins when both ids are equal
  assign is_steer    = (frames.data.frame_id == cfg_regs.steer_id);
  assign is_throttle = !is_steer && (frames.data.frame_id == cfg_regs.thr_id);

  // stick value and trim code
  assign stick = {frames.data.data_byte1[1:0], frames.data.data_byte0};
  assign off   = stick[8:0];
  assign code  = frames.data.data_byte1 & TRIM_CODE_MASK;

  // piecewise-linear map, slope 15/16, in sixteenths of a microsecond
  always_comb begin
    off15   = {off, 4'b0000} - {4'b0000, off};
    n_base  = (stick[9] ? BASE_HIGH16 : BASE_LOW16) - {3'b000, off15};
    n_dir   = is_throttle ? (MIRROR16 - n_base) : n_base;
    n_round = n_dir + HALF16;
  end

  // classified entry
  always_comb begin
    q_data.raw_pulse = n_round[15:4];
    if (is_steer) begin
      q_data.kind = KIND_STEER;
    end else if (is_throttle) begin
      q_data.kind = KIND_THROTTLE;
    end else begin
      q_data.kind = KIND_SILENCE;
    end
    if (code == TRIM_CODE_DOWN) begin
      q_data.trim_op = TRIM_DOWN;
    end else if (code == TRIM_CODE_UP) begin
      q_data.trim_op = TRIM_UP;
    end else begin
      q_data.trim_op = TRIM_HOLD;
    end
  end
endmodule

// ===== rtl/jfsp_back.sv =====
// ----------------------------------------------------------------------------
// jfsp_back
// Steps the channel trims and emits the silence and pulse results.
// ----------------------------------------------------------------------------
module jfsp_back (
  input  logic                 clk,
  input  logic                 rst,
  jfsp_chan_if.source          results,
  input  jfsp_pkg::cfg_regs_t  cfg_regs,
  input  jfsp_pkg::entry_t     head,
  input  logic                 q_empty,
  output logic                 q_pop
);
  import jfsp_pkg::*;

  logic              pulse_phase;
  logic              load;
  logic signed [9:0] steering_trim;
  logic signed [9:0] throttle_trim;
  logic signed [9:0] trim_cur;
  logic signed [10:0] lim;
  logic signed [10:0] t_dn;
  logic signed [10:0] t_up;
  logic signed [10:0] trim_next;
  logic signed [12:0] pulse_sum;
  logic              is_match;

  assign load     = !results.valid || results.ready;
  assign is_match = (head.kind != KIND_SILENCE);
  // silence-only frames leave after one result, matches after two
  assign q_pop    = load && !q_empty && (pulse_phase || !is_match);

  // trim step with saturation to the limit
  always_comb begin
    trim_cur = (head.kind == KIND_STEER) ? steering_trim : throttle_trim;
    lim      = signed'({2'b00, cfg_regs.trim_limit});
    t_dn     = 11'(trim_cur) - 11'sd2;
    t_up     = 11'(trim_cur) + 11'sd2;
    case (head.trim_op)
      TRIM_DOWN: trim_next = (t_dn < -lim) ? -lim : t_dn;
      TRIM_UP:   trim_next = (t_up > lim) ? lim : t_up;
      default:   trim_next = 11'(trim_cur);
    endcase
    pulse_sum = signed'({1'b0, head.raw_pulse}) + 13'(trim_next);
  end

  // result register, trims and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      pulse_phase   <= 1'b0;
      steering_trim <= '0;
      throttle_trim <= '0;
    end else if (load) begin
      results.valid <= !q_empty;
      if (!q_empty) begin
        if (!pulse_phase) begin
          results.data.frame_kind  <= KIND_SILENCE;
          results.data.pulse_width <= '0;
          results.data.last        <= !is_match;
          pulse_phase              <= is_match;
        end else begin
          results.data.frame_kind  <= head.kind;
          results.data.pulse_width <= pulse_sum[11:0];
          results.data.last        <= 1'b1;
          pulse_phase              <= 1'b0;
          if (head.kind == KIND_STEER) begin
            steering_trim <= trim_next[9:0];
          end else begin
            throttle_trim <= trim_next[9:0];
          end
        end
      end
    end
  end
endmodule

// ===== rtl/joystick_frame_to_servo_pulse.sv =====
// ----------------------------------------------------------------------------
// joystick_frame_to_servo_pulse
// Turns received joystick frames into receiver-silence and servo results.
// ----------------------------------------------------------------------------
// Channels: frames (sink) carries frame_id, data_byte0 and data_byte1; results
// (source) carries frame_kind, pulse_width and last; cfg (sink) writes the
// steering id, throttle id and trim limit by index and is always ready.
// Every frame gives a silence result; a frame matching the steering or the
// throttle id also gives a pulse result, with the channel trim stepped first.
// An accepted frame is stored in the queue; its results come from the output register.
// The back end emits one result per cycle while the results channel is not
// stalled, so a matching frame gives two results and any other frame one; a
// two-entry queue between the front and back lets frames arrive back to back.
// A stalled results channel holds its item; the front keeps accepting until
// the queue is full, then drops ready.
// Reset clears the queue, the trims and the output, and restores the ids and limit
// to their defaults. Configuration must be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module joystick_frame_to_servo_pulse #(
  parameter int QUEUE_DEPTH = jfsp_pkg::JFSP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  jfsp_chan_if.sink   frames,
  jfsp_chan_if.source results,
  jfsp_chan_if.sink   cfg
);
  import jfsp_pkg::*;

  cfg_regs_t cfg_regs;
  entry_t    q_in;
  entry_t    q_head;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  assign cfg.ready = 1'b1;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.steer_id   <= STEER_ID_RESET;
      cfg_regs.thr_id     <= THROTTLE_ID_RESET;
      cfg_regs.trim_limit <= TRIM_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_STEER_ID:    cfg_regs.steer_id   <= cfg.data.value;
        REG_THROTTLE_ID: cfg_regs.thr_id     <= cfg.data.value;
        REG_TRIM_LIMIT:  cfg_regs.trim_limit <= cfg.data.value[8:0];
        default: ;
      endcase
    end
  end

  jfsp_front u_front (
    .frames   (frames),
    .cfg_regs (cfg_regs),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  jfsp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  jfsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .results  (results),
    .cfg_regs (cfg_regs),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop)
  );
endmodule

// ===== rtl/jfsp_checker.sv =====
// ----------------------------------------------------------------------------
// jfsp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module jfsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_kind,
  input logic [11:0] res_pulse,
  input logic        res_last
);
  import jfsp_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("stalled result dropped");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable({res_kind, res_pulse, res_last}))
    else $error("stalled result changed");

  // silence results carry no pulse
  a_silence_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_SILENCE |-> res_pulse == '0)
    else $error("silence result with nonzero pulse");

  // a pulse result ends its frame and follows a silence result that did not
  a_pulse_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_kind == KIND_SILENCE && !res_last
    |=> res_valid && (res_kind == KIND_STEER || res_kind == KIND_THROTTLE)
        && res_last)
    else $error("pulse result missing after open silence result");
endmodule

bind joystick_frame_to_servo_pulse jfsp_checker u_jfsp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_kind  (results.data.frame_kind),
  .res_pulse (results.data.pulse_width),
  .res_last  (results.data.last)
);

// ===== tb/joystick_frame_to_servo_pulse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_frame_to_servo_pulse_checker
// Watches the frame, result and register channels of the servo pulse block,
// works out the silence and pulse items that each accepted frame must give,
// and compares every accepted result item field by field, in order.
// ----------------------------------------------------------------------------
module joystick_frame_to_servo_pulse_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                frm_valid,
  input  logic                frm_ready,
  input  jfsp_pkg::in_item_t  frm_data,
  input  logic                res_valid,
  input  logic                res_ready,
  input  jfsp_pkg::out_item_t res_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  jfsp_pkg::cfg_item_t cfg_data,
  output int                  failures,
  output int                  pending,
  output int                  results_seen
);
  import jfsp_pkg::*;

  // shadow registers and trims
  logic [10:0]       steer_id;
  logic [10:0]       thr_id;
  logic [8:0]        trim_limit;
  logic signed [9:0] steer_trim;
  logic signed [9:0] throttle_trim;

  // result items still owed by the block, oldest first
  out_item_t servo_backlog[$];

  initial begin
    failures     = 0;
    pending      = 0;
    results_seen = 0;
  end

  // one line per mismatch
  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    failures++;
  endtask

  // trim after one code, held inside the limit
  function automatic int stepped_trim(int t, logic [7:0] code, int lim);
    if (code == TRIM_CODE_DOWN) begin
      t = t - 2;
      if (t < -lim) t = -lim;
    end else if (code == TRIM_CODE_UP) begin
      t = t + 2;
      if (t > lim) t = lim;
    end
    return t;
  endfunction

  // stick value to pulse in us, slope 15/16, rounded half up
  function automatic int stick_pulse(int s, bit mirror);
    int base;
    int off;
    int n;
    base = (s < 512) ? 1500 : 2000;
    off  = (s < 512) ? s : s - 512;
    n    = 16 * base - 15 * off;
    if (mirror) n = 48000 - n;
    return (n + 8) / 16;
  endfunction

  // silence item always, then a pulse item on a matching id
  task automatic frame_to_results(in_item_t f);
    int        stick;
    int        p;
    logic [7:0] code;
    logic [1:0] kind;
    out_item_t  r;
    stick = int'({f.data_byte1[1:0], f.data_byte0});
    code  = f.data_byte1 & TRIM_CODE_MASK;
    kind  = KIND_SILENCE;
    p     = 0;
    if (f.frame_id == steer_id) begin
      kind       = KIND_STEER;
      steer_trim = 10'(stepped_trim(int'(steer_trim), code, int'(trim_limit)));
      p          = stick_pulse(stick, 1'b0) + int'(steer_trim);
    end else if (f.frame_id == thr_id) begin
      kind          = KIND_THROTTLE;
      throttle_trim = 10'(stepped_trim(int'(throttle_trim), code, int'(trim_limit)));
      p             = stick_pulse(stick, 1'b1) + int'(throttle_trim);
    end
    r.frame_kind  = KIND_SILENCE;
    r.pulse_width = '0;
    r.last        = (kind == KIND_SILENCE);
    servo_backlog.push_back(r);
    if (kind != KIND_SILENCE) begin
      r.frame_kind  = kind;
      r.pulse_width = 12'(p);
      r.last        = 1'b1;
      servo_backlog.push_back(r);
    end
  endtask

  // compare one result item with the oldest one owed
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (servo_backlog.size() == 0) begin
      flag_mismatch($sformatf("unexpected item kind %0d pulse %0d last %0d",
                              got.frame_kind, got.pulse_width, got.last));
    end else begin
      want = servo_backlog.pop_front();
      if (got.frame_kind !== want.frame_kind)
        flag_mismatch($sformatf("frame_kind %0d, want %0d", got.frame_kind,
                                want.frame_kind));
      if (got.pulse_width !== want.pulse_width)
        flag_mismatch($sformatf("pulse_width %0d, want %0d (kind %0d)",
                                got.pulse_width, want.pulse_width, want.frame_kind));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %0d, want %0d (kind %0d)", got.last,
                                want.last, want.frame_kind));
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      steer_id      = STEER_ID_RESET;
      thr_id        = THROTTLE_ID_RESET;
      trim_limit    = TRIM_LIMIT_RESET;
      steer_trim    = '0;
      throttle_trim = '0;
      servo_backlog.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_STEER_ID:    steer_id   = cfg_data.value;
          REG_THROTTLE_ID: thr_id     = cfg_data.value;
          REG_TRIM_LIMIT:  trim_limit = cfg_data.value[8:0];
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        results_seen++;
        check_result(res_data);
      end
      if (frm_valid && frm_ready) frame_to_results(frm_data);
    end
    pending = servo_backlog.size();
  end

endmodule

// ===== tb/joystick_frame_to_servo_pulse_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_frame_to_servo_pulse_test
// Drives frames and register writes into the servo pulse block: a directed
// run over stick extremes, trim codes and id corner cases, then random
// phases under several register settings, most with random stalls on both sides.
// ----------------------------------------------------------------------------
module joystick_frame_to_servo_pulse_test;
  import jfsp_pkg::*;

  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         PHASES          = 6;
  localparam int         FRAMES_PER_PHASE = 80;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_on = 1'b1;
  int   cycle_count = 0;
  int   stall_left = 0;
  int   frames_sent = 0;
  int   reg_writes = 0;
  int   failures;
  int   pending;
  int   results_seen;

  jfsp_chan_if #(.T(in_item_t))  frames_ch ();
  jfsp_chan_if #(.T(out_item_t)) results_ch ();
  jfsp_chan_if #(.T(cfg_item_t)) cfg_ch ();

  joystick_frame_to_servo_pulse dut (
    .clk     (clk),
    .rst     (rst),
    .frames  (frames_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  joystick_frame_to_servo_pulse_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .frm_valid    (frames_ch.valid),
    .frm_ready    (frames_ch.ready),
    .frm_data     (frames_ch.data),
    .res_valid    (results_ch.valid),
    .res_ready    (results_ch.ready),
    .res_data     (results_ch.data),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_data     (cfg_ch.data),
    .failures     (failures),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d items owed", pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left        <= stall_left - 1;
      results_ch.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left        <= $urandom_range(1, 14) - 1;
      results_ch.ready  <= 1'b0;
    end else begin
      results_ch.ready  <= 1'b1;
    end
  end

  // present one frame and wait until it is taken
  task automatic send_frame(logic [10:0] id, logic [7:0] b0, logic [7:0] b1);
    @(negedge clk);
    frames_ch.valid           <= 1'b1;
    frames_ch.data.frame_id   <= id;
    frames_ch.data.data_byte0 <= b0;
    frames_ch.data.data_byte1 <= b1;
    @(posedge clk);
    while (!frames_ch.ready) @(posedge clk);
    frames_sent++;
  endtask

  // sender drops valid and stays idle for a span set by n
  task automatic idle_frames(int n);
    @(negedge clk);
    frames_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // random gap after a frame
  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 7) == 0) idle_frames($urandom_range(1, 14));
  endtask

  // stop sending and wait for every owed item
  task automatic settle();
    @(negedge clk);
    frames_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] value);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
  endtask

  // one random frame, mostly on the configured ids, trim codes biased
  task automatic random_frame(logic [10:0] sid, logic [10:0] tid, int up_bias);
    int         pick;
    logic [10:0] id;
    logic [7:0]  code;
    pick = $urandom_range(0, 9);
    if (pick < 4) id = sid;
    else if (pick < 8) id = tid;
    else id = 11'($urandom_range(0, 2047));
    pick = $urandom_range(0, 9);
    if (pick < up_bias) code = TRIM_CODE_UP;
    else if (pick < 8) code = TRIM_CODE_DOWN;
    else code = 8'($urandom_range(0, 63) << 2);
    send_frame(id, 8'($urandom_range(0, 255)), code | 8'($urandom_range(0, 3)));
    maybe_gap();
  endtask

  initial begin
    logic [10:0] sid;
    logic [10:0] tid;
    logic [8:0]  lim;
    int          bias;
    frames_ch.valid  = 1'b0;
    frames_ch.data   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    results_ch.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // stick extremes on both channels at the reset settings
    send_frame(STEER_ID_RESET, 8'h00, 8'h00);
    send_frame(STEER_ID_RESET, 8'hFF, 8'h01);
    send_frame(STEER_ID_RESET, 8'h00, 8'h02);
    send_frame(STEER_ID_RESET, 8'hFF, 8'h03);
    send_frame(THROTTLE_ID_RESET, 8'h00, 8'h00);
    send_frame(THROTTLE_ID_RESET, 8'hFF, 8'h01);
    send_frame(THROTTLE_ID_RESET, 8'h00, 8'h02);
    send_frame(THROTTLE_ID_RESET, 8'hFF, 8'h03);
    // trim codes down, up and neither
    send_frame(STEER_ID_RESET, 8'h80, TRIM_CODE_DOWN | 8'h01);
    send_frame(STEER_ID_RESET, 8'h80, TRIM_CODE_UP);
    send_frame(THROTTLE_ID_RESET, 8'h40, TRIM_CODE_DOWN);
    send_frame(THROTTLE_ID_RESET, 8'h40, TRIM_CODE_UP | 8'h02);
    send_frame(STEER_ID_RESET, 8'h55, 8'hFC);
    send_frame(STEER_ID_RESET, 8'hAA, 8'h0C);
    // ids that match nothing
    send_frame(11'h000, 8'hFF, 8'hFF);
    send_frame(11'h7FF, 8'h00, 8'h00);

    // odd limit is reached exactly, upper value bits ignored
    settle();
    write_reg(REG_TRIM_LIMIT, 11'h601);
    repeat (2) send_frame(STEER_ID_RESET, 8'h10, TRIM_CODE_UP);
    repeat (2) send_frame(STEER_ID_RESET, 8'h10, TRIM_CODE_DOWN);
    // lowered limit pulls the trim in on the next step
    settle();
    write_reg(REG_TRIM_LIMIT, 11'h000);
    send_frame(STEER_ID_RESET, 8'h10, TRIM_CODE_UP);
    // both ids equal: steering wins; unknown index changes nothing
    settle();
    write_reg(REG_STEER_ID, 11'h7FF);
    write_reg(REG_THROTTLE_ID, 11'h7FF);
    send_frame(11'h7FF, 8'h20, TRIM_CODE_UP | 8'h03);
    settle();
    write_reg(REG_UNUSED, 11'h7FF);
    send_frame(11'h7FF, 8'hC3, 8'h01);

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin sid = 11'h000; tid = 11'h7FF; lim = 9'd511; end
        1: begin sid = 11'h7FF; tid = 11'h000; lim = 9'd0; end
        2: begin sid = 11'($urandom_range(0, 2047)); tid = ~sid; lim = 9'd3; end
        3: begin sid = STEER_ID_RESET; tid = THROTTLE_ID_RESET; lim = 9'd500; end
        default: begin
          sid = 11'($urandom_range(0, 2047));
          tid = 11'($urandom_range(0, 2047));
          lim = 9'($urandom_range(0, 40));
        end
      endcase
      // quiet final phase
      if (p == PHASES - 1) idle_on = 1'b0;
      bias = $urandom_range(1, 7);
      settle();
      write_reg(REG_STEER_ID, sid);
      write_reg(REG_THROTTLE_ID, tid);
      write_reg(REG_TRIM_LIMIT, {2'($urandom_range(0, 3)), lim});
      for (int i = 0; i < FRAMES_PER_PHASE; i++) random_frame(sid, tid, bias);
    end

    // drain
    settle();
    repeat (10) @(negedge clk);
    $display("%0d frames sent, %0d result items checked", frames_sent, results_seen);
    $display("%0d register writes over %0d random settings", reg_writes, PHASES);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
